// ----- src/dtw_pkg.sv -----
// Package for the decision tree walker: table sizes, node entry layout,
// operator, variable and function codes, and the walker state type. No dependencies.
package dtw_pkg;

    localparam int NODE_COUNT  = 32;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int MAX_STEPS   = 32;
    localparam int STEP_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int VALUE_WIDTH = 32;
    localparam int OP_W        = 3;
    localparam int VAR_W       = 2;
    localparam int ACTION_W    = 8;
    localparam int IDX_W       = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ALWAYS  = 3'd0,
        OP_GREATER = 3'd1,
        OP_LESS    = 3'd2,
        OP_EQUAL   = 3'd3,
        OP_NEQUAL  = 3'd4
    } t_op;

    localparam logic [VAR_W-1:0] VAR_PROGRESS  = 2'd0;
    localparam logic [VAR_W-1:0] VAR_REMAINDER = 2'd1;
    localparam logic [VAR_W-1:0] VAR_TARGET_HP = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]              op;
        logic [VAR_W-1:0]             var_sel;
        logic signed [VALUE_WIDTH-1:0] threshold;
        logic [NODE_W-1:0]            left;
        logic [NODE_W-1:0]            right;
        logic [ACTION_W-1:0]          action;
    } t_node;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACK,
        S_EVAL
    } t_state;

endpackage

// ----- src/dtw_if.sv -----
// Item channel interfaces of the decision tree walker: input and result channels
// with valid/ready handshake. Depend on dtw_pkg for field widths.
interface dtw_in_if import dtw_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [IDX_W-1:0]               node_index;
    logic [OP_W-1:0]                node_op;
    logic [VAR_W-1:0]               node_var;
    logic signed [VALUE_WIDTH-1:0]  node_threshold;
    logic [IDX_W-1:0]               node_left;
    logic [IDX_W-1:0]               node_right;
    logic [ACTION_W-1:0]            node_action;
    logic signed [VALUE_WIDTH-1:0]  var_progress;
    logic signed [VALUE_WIDTH-1:0]  var_remainder;
    logic signed [VALUE_WIDTH-1:0]  var_target_hp;

    modport source (
        output valid, func, node_index, node_op, node_var, node_threshold,
               node_left, node_right, node_action, var_progress, var_remainder,
               var_target_hp,
        input  ready
    );
    modport sink (
        input  valid, func, node_index, node_op, node_var, node_threshold,
               node_left, node_right, node_action, var_progress, var_remainder,
               var_target_hp,
        output ready
    );
endinterface

interface dtw_out_if import dtw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    visited_node;
    logic                went_left;
    logic [ACTION_W-1:0] action_code;
    logic                overrun;
    logic                last;

    modport source (
        output valid, visited_node, went_left, action_code, overrun, last,
        input  ready
    );
    modport sink (
        input  valid, visited_node, went_left, action_code, overrun, last,
        output ready
    );
endinterface

// ----- src/dtw_node_ram.sv -----
// Node table of the decision tree walker: one write port, one read port,
// registered read data. Depends on dtw_pkg for the entry layout.
module dtw_node_ram import dtw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [NODE_W-1:0] i_wr_addr,
    input  t_node             i_wr_data,
    input  logic              i_rd_en,
    input  logic [NODE_W-1:0] i_rd_addr,
    output t_node             o_rd_data
);

    t_node r_mem [NODE_COUNT];
    t_node r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/decision_tree_walker.sv -----
// Decision tree walker top level: node table memory, walk sequencer and result
// register. Depends on dtw_pkg, dtw_if.sv and dtw_node_ram.
//
// Load item: written in its accept cycle; its acknowledge enters the result register
//   in that cycle when free, else from S_ACK. Evaluate item: root read at accept, then
//   one result per cycle while the result register is free, one table read per visited
//   node, at most MAX_STEPS nodes; no new item is taken until the walk ends.
// Reset (synchronous, active low) clears the sequencer and result valid; the node
// table is not cleared and holds garbage until each entry is loaded.
module decision_tree_walker import dtw_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dtw_in_if.sink         i_in,
    dtw_out_if.source      o_out
);

    // Sequencer state
    t_state                        r_state, n_state;
    logic [NODE_W-1:0]             r_pos, n_pos;
    logic [STEP_W-1:0]             r_step, n_step;

    // Operands latched from the evaluate item
    logic signed [VALUE_WIDTH-1:0] r_var_progress;
    logic signed [VALUE_WIDTH-1:0] r_var_remainder;
    logic signed [VALUE_WIDTH-1:0] r_var_target_hp;

    // Pending load acknowledge
    logic [IDX_W-1:0]              r_ack_idx;
    logic [ACTION_W-1:0]           r_ack_action;

    // Result register
    logic                          r_out_valid;
    logic [IDX_W-1:0]              r_out_node;
    logic                          r_out_left;
    logic [ACTION_W-1:0]           r_out_action;
    logic                          r_out_overrun;
    logic                          r_out_last;

    // Table port
    logic                          wr_en;
    t_node                         wr_data;
    logic                          rd_en;
    logic [NODE_W-1:0]             rd_addr;
    t_node                         node;

    // Step evaluation
    logic                          in_ready;
    logic                          in_acc;
    logic                          out_free;
    logic signed [VALUE_WIDTH-1:0] sel_val;
    logic                          cmp_true;
    logic [NODE_W-1:0]             next_idx;
    logic                          walk_end;
    logic                          at_limit;

    // Result push
    logic                          push;
    logic [IDX_W-1:0]              push_node;
    logic                          push_left;
    logic [ACTION_W-1:0]           push_action;
    logic                          push_overrun;

    dtw_node_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in.node_index[NODE_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (node)
    );

    assign in_ready = (r_state == S_IDLE);
    assign in_acc   = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign wr_data.op        = i_in.node_op;
    assign wr_data.var_sel   = i_in.node_var;
    assign wr_data.threshold = i_in.node_threshold;
    assign wr_data.left      = i_in.node_left[NODE_W-1:0];
    assign wr_data.right     = i_in.node_right[NODE_W-1:0];
    assign wr_data.action    = i_in.node_action;

    // Pick the tested variable; the unused code tests progress
    always_comb begin
        case (node.var_sel)
            VAR_REMAINDER: sel_val = r_var_remainder;
            VAR_TARGET_HP: sel_val = r_var_target_hp;
            default:       sel_val = r_var_progress;
        endcase
    end

    // Compare; unknown operators go right
    always_comb begin
        unique case (node.op)
            OP_ALWAYS:  cmp_true = 1'b1;
            OP_GREATER: cmp_true = sel_val > $signed(node.threshold);
            OP_LESS:    cmp_true = sel_val < $signed(node.threshold);
            OP_EQUAL:   cmp_true = sel_val == $signed(node.threshold);
            OP_NEQUAL:  cmp_true = sel_val != $signed(node.threshold);
            default:    cmp_true = 1'b0;
        endcase
    end

    assign next_idx = cmp_true ? node.left : node.right;
    assign at_limit = (r_step == STEP_W'(MAX_STEPS - 1));
    // Child index zero, the root, closes the walk; so does reaching the step limit
    assign walk_end = (next_idx == '0) || at_limit;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.func == FUNC_EVAL) begin
                    n_state = S_EVAL;
                end else if (in_acc && !out_free) begin
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                if (out_free && walk_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: table accesses, counters and result push
    always_comb begin
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_pos;
        n_pos        = r_pos;
        n_step       = r_step;
        push         = 1'b0;
        push_node    = r_ack_idx;
        push_left    = 1'b0;
        push_action  = r_ack_action;
        push_overrun = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.func == FUNC_EVAL) begin
                    // Start at the root
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_pos   = '0;
                    n_step  = '0;
                end else if (in_acc) begin
                    wr_en       = 1'b1;
                    push        = out_free;
                    push_node   = i_in.node_index;
                    push_action = i_in.node_action;
                end
            end
            S_ACK: begin
                push = out_free;
            end
            S_EVAL: begin
                push         = out_free;
                push_node    = IDX_W'(r_pos);
                push_left    = cmp_true;
                push_action  = node.action;
                push_overrun = at_limit && (next_idx != '0);
                if (out_free && !walk_end) begin
                    // Advance to the chosen child
                    rd_en   = 1'b1;
                    rd_addr = next_idx;
                    n_pos   = next_idx;
                    n_step  = r_step + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_step  <= n_step;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.func == FUNC_EVAL) begin
            r_var_progress  <= i_in.var_progress;
            r_var_remainder <= i_in.var_remainder;
            r_var_target_hp <= i_in.var_target_hp;
        end
        if (in_acc) begin
            r_ack_idx    <= i_in.node_index;
            r_ack_action <= i_in.node_action;
        end
        if (push) begin
            r_out_node    <= push_node;
            r_out_left    <= push_left;
            r_out_action  <= push_action;
            r_out_overrun <= push_overrun;
            // A load ack is always last; a walk step is last where the walk ends
            r_out_last    <= (r_state == S_EVAL) ? walk_end : 1'b1;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.visited_node  = r_out_node;
    assign o_out.went_left     = r_out_left;
    assign o_out.action_code   = r_out_action;
    assign o_out.overrun       = r_out_overrun;
    assign o_out.last          = r_out_last;

    // Table is never read and written in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("node table read and write in one cycle");

    // An evaluate item starts a walk in the next cycle
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.func == FUNC_EVAL |=> r_state == S_EVAL)
        else $error("evaluate item did not start a walk");

    // An overrun result closes the walk
    a_overrun_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_overrun |-> r_out_last)
        else $error("overrun result not marked last");

    // The step count and position hold while a walk waits on a full result register
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL && !out_free |=> $stable(r_step) && $stable(r_pos))
        else $error("walk advanced while the result register was full");

endmodule
